// ----- hw/rtl/bfha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit heap allocator package
// Shared constants, codes and the command and status types that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package bfha_pkg;

    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int GRANULE_BYTES    = 4;
    localparam int REQ_W            = 13;
    localparam int OFF_W            = 12;
    localparam int ST_W             = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_FIT   = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_NEXT_RD,
        S_MERGE,
        S_FREE_WR,
        S_SPLIT,
        S_BEST,
        S_RESP
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_INIT,
        DP_LOAD,
        DP_READ_POS,
        DP_WALK_ALLOC,
        DP_WALK_FREE,
        DP_FREE_HIT,
        DP_READ_NEXT,
        DP_MERGE,
        DP_WRITE_FREE,
        DP_WRITE_SPLIT,
        DP_WRITE_BEST,
        DP_RESPOND
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic size_zero;
        logic walk_end;
        logic match;
        logic found;
        logic split_ok;
        logic next_in_heap;
    } t_dp_sts;

endpackage

// ----- hw/rtl/bfha_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit heap allocator controller
// Sequences the header walk, the free-time merge and the header writes.
// ----------------------------------------------------------------------------
module bfha_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bfha_pkg::t_dp_sts  i_sts,
    output bfha_pkg::t_dp_cmd  o_cmd
);

    bfha_pkg::t_state r_state;
    bfha_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfha_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfha_pkg::S_INIT: begin
                n_state = bfha_pkg::S_IDLE;
            end
            bfha_pkg::S_IDLE: begin
                if (start) begin
                    n_state = bfha_pkg::S_READ;
                end
            end
            bfha_pkg::S_READ: begin
                if (!i_sts.is_free && i_sts.size_zero) begin
                    n_state = bfha_pkg::S_IDLE;
                end else if (i_sts.walk_end) begin
                    if (!i_sts.is_free && i_sts.found) begin
                        n_state = i_sts.split_ok ? bfha_pkg::S_SPLIT : bfha_pkg::S_BEST;
                    end else begin
                        n_state = bfha_pkg::S_IDLE;
                    end
                end else begin
                    n_state = bfha_pkg::S_EVAL;
                end
            end
            bfha_pkg::S_EVAL: begin
                if (i_sts.is_free && i_sts.match) begin
                    n_state = bfha_pkg::S_NEXT_RD;
                end else begin
                    n_state = bfha_pkg::S_READ;
                end
            end
            bfha_pkg::S_NEXT_RD: begin
                n_state = i_sts.next_in_heap ? bfha_pkg::S_MERGE : bfha_pkg::S_FREE_WR;
            end
            bfha_pkg::S_MERGE: begin
                n_state = bfha_pkg::S_FREE_WR;
            end
            bfha_pkg::S_FREE_WR: begin
                n_state = bfha_pkg::S_RESP;
            end
            bfha_pkg::S_SPLIT: begin
                n_state = bfha_pkg::S_BEST;
            end
            bfha_pkg::S_BEST: begin
                n_state = bfha_pkg::S_RESP;
            end
            bfha_pkg::S_RESP: begin
                n_state = bfha_pkg::S_IDLE;
            end
            default: begin
                n_state = bfha_pkg::S_INIT;
            end
        endcase
    end

    always_comb begin
        o_cmd.op     = bfha_pkg::DP_NOP;
        o_cmd.status = bfha_pkg::ST_OK;
        busy         = 1'b1;
        unique case (r_state)
            bfha_pkg::S_INIT: begin
                o_cmd.op = bfha_pkg::DP_INIT;
            end
            bfha_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.op = bfha_pkg::DP_LOAD;
                end
            end
            bfha_pkg::S_READ: begin
                if (!i_sts.is_free && i_sts.size_zero) begin
                    o_cmd.op     = bfha_pkg::DP_RESPOND;
                    o_cmd.status = bfha_pkg::ST_BAD_SIZE;
                end else if (i_sts.walk_end) begin
                    if (i_sts.is_free) begin
                        o_cmd.op     = bfha_pkg::DP_RESPOND;
                        o_cmd.status = bfha_pkg::ST_BAD_FREE;
                    end else if (!i_sts.found) begin
                        o_cmd.op     = bfha_pkg::DP_RESPOND;
                        o_cmd.status = bfha_pkg::ST_NO_FIT;
                    end
                end else begin
                    o_cmd.op = bfha_pkg::DP_READ_POS;
                end
            end
            bfha_pkg::S_EVAL: begin
                if (!i_sts.is_free) begin
                    o_cmd.op = bfha_pkg::DP_WALK_ALLOC;
                end else if (i_sts.match) begin
                    o_cmd.op = bfha_pkg::DP_FREE_HIT;
                end else begin
                    o_cmd.op = bfha_pkg::DP_WALK_FREE;
                end
            end
            bfha_pkg::S_NEXT_RD: begin
                if (i_sts.next_in_heap) begin
                    o_cmd.op = bfha_pkg::DP_READ_NEXT;
                end
            end
            bfha_pkg::S_MERGE: begin
                o_cmd.op = bfha_pkg::DP_MERGE;
            end
            bfha_pkg::S_FREE_WR: begin
                o_cmd.op = bfha_pkg::DP_WRITE_FREE;
            end
            bfha_pkg::S_SPLIT: begin
                o_cmd.op = bfha_pkg::DP_WRITE_SPLIT;
            end
            bfha_pkg::S_BEST: begin
                o_cmd.op = bfha_pkg::DP_WRITE_BEST;
            end
            bfha_pkg::S_RESP: begin
                o_cmd.op = bfha_pkg::DP_RESPOND;
            end
            default: begin
                o_cmd.op = bfha_pkg::DP_NOP;
            end
        endcase
    end

endmodule

// ----- hw/rtl/bfha_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit heap allocator datapath
// Header memory, walk registers, best-fit tracking and the result register.
// ----------------------------------------------------------------------------
module bfha_datapath #(
    parameter int HEAP_BYTES   = bfha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfha_pkg::t_dp_cmd             i_cmd,
    output bfha_pkg::t_dp_sts             o_sts,
    input  logic                          i_command,
    input  logic [bfha_pkg::REQ_W-1:0]    i_request_size,
    input  logic [bfha_pkg::OFF_W-1:0]    i_free_offset,
    output logic                          o_done,
    output logic [bfha_pkg::ST_W-1:0]     o_status,
    output logic [bfha_pkg::OFF_W-1:0]    o_payload_offset
);

    localparam int GRANULES = HEAP_BYTES / bfha_pkg::GRANULE_BYTES;
    localparam int DW       = $clog2(HEAP_BYTES);
    localparam int GW       = $clog2(GRANULES);
    localparam int AW       = (DW + 1 > bfha_pkg::REQ_W + 1) ? DW + 1 : bfha_pkg::REQ_W + 1;

    localparam logic [AW-1:0] HEAP_A    = AW'(HEAP_BYTES);
    localparam logic [AW-1:0] HDR_A     = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] RND_A     = AW'(bfha_pkg::GRANULE_BYTES - 1);
    localparam logic [AW-1:0] SPLIT_MIN = AW'(bfha_pkg::GRANULE_BYTES + HEADER_BYTES);
    localparam logic [DW-1:0] INIT_SIZE = DW'(HEAP_BYTES - HEADER_BYTES);

    logic [DW-1:0]               r_mem [GRANULES];
    logic [DW-1:0]               r_rdata;

    logic                        r_cmd;
    logic                        r_zero;
    logic [AW-1:0]               r_req;
    logic [bfha_pkg::OFF_W-1:0]  r_off;
    logic [AW-1:0]               r_pos;
    logic [AW-1:0]               r_best;
    logic [AW-1:0]               r_best_size;
    logic                        r_found;
    logic [AW-1:0]               r_prev;
    logic [AW-1:0]               r_prev_size;
    logic                        r_prev_busy;
    logic                        r_have_prev;
    logic [AW-1:0]               r_sz;
    logic                        r_done;
    logic [bfha_pkg::ST_W-1:0]   r_status;
    logic [bfha_pkg::OFF_W-1:0]  r_payload;

    logic [AW-1:0] w_rd_size;
    logic          w_rd_busy;
    logic [AW-1:0] w_nxt;
    logic [AW-1:0] w_fix_nxt;
    logic [AW-1:0] w_spare;
    logic [AW-1:0] w_split;
    logic          w_fits;
    logic          w_we;
    logic [GW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [GW-1:0] w_raddr;

    // The busy flag sits in bit 0 of a header; sizes are whole granules.
    assign w_rd_size = AW'({r_rdata[DW-1:1], 1'b0});
    assign w_rd_busy = r_rdata[0];
    assign w_nxt     = r_pos + HDR_A + w_rd_size;
    assign w_fix_nxt = r_pos + HDR_A + r_sz;
    assign w_spare   = r_best_size - r_req;
    assign w_split   = r_best + HDR_A + r_req;
    assign w_fits    = !w_rd_busy && (w_rd_size >= r_req)
                       && (!r_found || (w_rd_size < r_best_size));

    assign o_sts.is_free      = (r_cmd == bfha_pkg::CMD_FREE);
    assign o_sts.size_zero    = r_zero;
    assign o_sts.walk_end     = (r_pos >= HEAP_A);
    assign o_sts.match        = w_rd_busy && ((r_pos + HDR_A) == AW'(r_off));
    assign o_sts.found        = r_found;
    assign o_sts.split_ok     = (w_spare >= SPLIT_MIN);
    assign o_sts.next_in_heap = (w_fix_nxt < HEAP_A);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos[DW-1:2];
        w_wdata = '0;
        unique case (i_cmd.op)
            bfha_pkg::DP_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = INIT_SIZE;
            end
            bfha_pkg::DP_WRITE_FREE: begin
                w_we = 1'b1;
                if (r_have_prev && !r_prev_busy) begin
                    w_waddr = r_prev[DW-1:2];
                    w_wdata = DW'(r_prev_size + HDR_A + r_sz);
                end else begin
                    w_waddr = r_pos[DW-1:2];
                    w_wdata = DW'(r_sz);
                end
            end
            bfha_pkg::DP_WRITE_SPLIT: begin
                w_we    = 1'b1;
                w_waddr = w_split[DW-1:2];
                w_wdata = DW'(w_spare - HDR_A);
            end
            bfha_pkg::DP_WRITE_BEST: begin
                w_we    = 1'b1;
                w_waddr = r_best[DW-1:2];
                w_wdata = DW'(r_best_size) | DW'(1);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_raddr = (i_cmd.op == bfha_pkg::DP_READ_NEXT) ? w_fix_nxt[DW-1:2] : r_pos[DW-1:2];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            bfha_pkg::DP_LOAD: begin
                r_cmd       <= i_command;
                r_zero      <= (i_request_size == '0);
                r_req       <= (AW'(i_request_size) + RND_A) & ~RND_A;
                r_off       <= i_free_offset;
                r_pos       <= '0;
                r_found     <= 1'b0;
                r_have_prev <= 1'b0;
            end
            bfha_pkg::DP_WALK_ALLOC: begin
                if (w_fits) begin
                    r_found     <= 1'b1;
                    r_best      <= r_pos;
                    r_best_size <= w_rd_size;
                end
                r_pos <= w_nxt;
            end
            bfha_pkg::DP_WALK_FREE: begin
                r_prev      <= r_pos;
                r_prev_size <= w_rd_size;
                r_prev_busy <= w_rd_busy;
                r_have_prev <= 1'b1;
                r_pos       <= w_nxt;
            end
            bfha_pkg::DP_FREE_HIT: begin
                r_sz <= w_rd_size;
            end
            bfha_pkg::DP_MERGE: begin
                if (!w_rd_busy) begin
                    r_sz <= r_sz + HDR_A + w_rd_size;
                end
            end
            bfha_pkg::DP_WRITE_SPLIT: begin
                r_best_size <= r_req;
            end
            default: begin
                r_sz <= r_sz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd.op == bfha_pkg::DP_RESPOND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bfha_pkg::DP_RESPOND) begin
            r_status <= i_cmd.status;
            if ((i_cmd.status == bfha_pkg::ST_OK) && (r_cmd == bfha_pkg::CMD_ALLOC)) begin
                r_payload <= bfha_pkg::OFF_W'(r_best + HDR_A);
            end else begin
                r_payload <= '0;
            end
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_payload_offset = r_payload;

endmodule

// ----- hw/rtl/best_fit_heap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit heap allocator
// Sequence: an allocate walks all N blocks, writes the remainder header when the best fit can be
// split, then marks the best block busy; a free walks up to the block it hits, folds in a free next
// block, then writes the merged free header; a zero-size allocate is refused at once. Words are
// taken one at a time, busy high until the result; each block is one header memory read and one
// evaluation. Reset: synchronous; after reset the S_INIT state writes the initial free block
// header, with busy high. The receiver cannot stall: o_done marks each result for one cycle.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator #(
    parameter int HEAP_BYTES   = bfha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [bfha_pkg::REQ_W-1:0]    i_request_size,
    input  logic [bfha_pkg::OFF_W-1:0]    i_free_offset,
    output logic                          o_done,
    output logic [bfha_pkg::ST_W-1:0]     o_status,
    output logic [bfha_pkg::OFF_W-1:0]    o_payload_offset
);

    // The controller and datapath talk only through these two bundles.
    bfha_pkg::t_dp_cmd w_cmd;
    bfha_pkg::t_dp_sts w_sts;

    // The controller walks the block chain from offset zero, reading and then
    // evaluating each header, then issues the split, mark or merge writes.
    bfha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the header memory (one entry per four-byte granule)
    // and the best-fit and neighbour registers. Only headers reachable along
    // the chain are ever read, so stale entries need no clearing.
    bfha_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_command        (i_command),
        .i_request_size   (i_request_size),
        .i_free_offset    (i_free_offset),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset)
    );

    // A result is only ever presented once the controller is back at rest.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result presented while busy");

    // An accepted word always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start work");

    // Exactly one result per word: strobes never come back to back.
    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("repeated result strobe");

    // A failed request reports a zero offset.
    a_fail_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != bfha_pkg::ST_OK)) |-> (o_payload_offset == '0))
        else $error("non-zero offset on failure");

endmodule
